/* src/halfband_decimator_stereo_top_assert.svh */
// ----------------------------------------------------------------------------
// halfband decimator assertion macros
// shared property forms for the stereo half-band decimator checks
// ----------------------------------------------------------------------------
`ifndef HALFBAND_DECIMATOR_STEREO_TOP_ASSERT_SVH
`define HALFBAND_DECIMATOR_STEREO_TOP_ASSERT_SVH

// same-cycle implication under reset
`define HBDS_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("hbds check failed");

// next-cycle implication under reset
`define HBDS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("hbds check failed");

`endif

/* src/hbds_pkg.sv */
// ----------------------------------------------------------------------------
// hbds_pkg
// types, constants and coefficient table for the stereo half-band decimator
// ----------------------------------------------------------------------------
package hbds_pkg;

	localparam int SAMPLE_W    = 32;
	localparam int COEF_W      = 16;
	localparam int PROD_W      = SAMPLE_W + COEF_W;
	localparam int TAP_COUNT   = 15;
	localparam int SAMPLE_BITS = 32;
	localparam int NARROW_W    = 16;
	localparam int WIDEN_SHIFT = 12;
	localparam int FRAC_BITS   = 15;
	localparam int ROUND_HALF  = 16384;
	localparam int COEF_LEN    = 15;
	localparam int COEF_IDX_W  = $clog2(COEF_LEN);

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 1;

	localparam logic [CFG_INDEX_W-1:0] CFG_DECIMATE = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_NARROW   = CFG_INDEX_W'(1);

	localparam logic signed [COEF_W-1:0] HB_COEF [COEF_LEN] = '{
		16'sd0, 16'sd188, 16'sd0, -16'sd1595, 16'sd0, 16'sd9590, 16'sd0, 16'sd16384,
		16'sd0, 16'sd9590, 16'sd0, -16'sd1595, 16'sd0, 16'sd188, 16'sd0
	};

	typedef struct packed {
		logic valid;
		logic pass;
	} ctl_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filt;
		logic signed [SAMPLE_W-1:0] wide;
	} lane_out_t;

	function automatic logic signed [COEF_W-1:0] hb_coef(input int t);
		logic signed [COEF_W-1:0] c;
		c = '0;
		if (t < COEF_LEN) begin
			c = HB_COEF[COEF_IDX_W'(t)];
		end
		return c;
	endfunction

endpackage

/* src/hbds_lane.sv */
// ----------------------------------------------------------------------------
// hbds_lane
// one channel: widening, delay line, tap products, sum, rounding and clamp
// ----------------------------------------------------------------------------
module hbds_lane #(
	parameter int TAP_COUNT = hbds_pkg::TAP_COUNT
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  logic                                 shift_en,
	input  logic                                 narrow,
	input  logic signed [hbds_pkg::SAMPLE_W-1:0] sample,
	output hbds_pkg::lane_out_t                  res
);

	localparam int SW    = hbds_pkg::SAMPLE_W;
	localparam int PW    = hbds_pkg::PROD_W;
	localparam int SUM_W = PW + $clog2(TAP_COUNT);
	localparam int EXT_W = SW - hbds_pkg::NARROW_W - hbds_pkg::WIDEN_SHIFT;

	localparam logic signed [SUM_W-1:0] HALF   = SUM_W'(hbds_pkg::ROUND_HALF);
	localparam logic signed [SUM_W-1:0] SAT_HI =
		SUM_W'((longint'(1) <<< (hbds_pkg::SAMPLE_BITS - 1)) - longint'(1));
	localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

	logic signed [SW-1:0]    wide;
	logic signed [SW-1:0]    line_q [TAP_COUNT-1];
	logic signed [SW-1:0]    taps [TAP_COUNT];
	logic signed [PW-1:0]    prod_s1 [TAP_COUNT];
	logic signed [SW-1:0]    wide_s1;
	logic signed [SUM_W-1:0] sum_s2;
	logic signed [SW-1:0]    wide_s2;
	logic signed [SUM_W-1:0] sum_d;
	logic signed [SUM_W-1:0] rnd;
	logic signed [SUM_W-1:0] shifted;
	logic signed [SUM_W-1:0] clamped;

	always_comb begin
		if (narrow) begin
			wide = {{EXT_W{sample[hbds_pkg::NARROW_W-1]}}, sample[hbds_pkg::NARROW_W-1:0],
				{hbds_pkg::WIDEN_SHIFT{1'b0}}};
		end else begin
			wide = sample;
		end
	end

	always_comb begin
		taps[0] = wide;
		for (int t = 1; t < TAP_COUNT; t++) begin
			taps[t] = line_q[t-1];
		end
	end

	// delay line, newest first
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < TAP_COUNT - 1; t++) begin
				line_q[t] <= '0;
			end
		end else if (shift_en) begin
			line_q[0] <= wide;
			for (int t = 1; t < TAP_COUNT - 1; t++) begin
				line_q[t] <= line_q[t-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int t = 0; t < TAP_COUNT; t++) begin
				prod_s1[t] <= PW'(hbds_pkg::hb_coef(t)) * PW'(taps[t]);
			end
			wide_s1 <= wide;
		end
	end

	always_comb begin
		sum_d = '0;
		for (int t = 0; t < TAP_COUNT; t++) begin
			sum_d = sum_d + SUM_W'(prod_s1[t]);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s2  <= sum_d;
			wide_s2 <= wide_s1;
		end
	end

	// negative sums round via floor of (sum - half)
	always_comb begin
		rnd     = sum_s2[SUM_W-1] ? (sum_s2 - HALF) : (sum_s2 + HALF);
		shifted = rnd >>> hbds_pkg::FRAC_BITS;
		if (shifted > SAT_HI) begin
			clamped = SAT_HI;
		end else if (shifted < SAT_LO) begin
			clamped = SAT_LO;
		end else begin
			clamped = shifted;
		end
	end

	assign res.filt = clamped[SW-1:0];
	assign res.wide = wide_s2;

endmodule

/* src/hbds_merge.sv */
// ----------------------------------------------------------------------------
// hbds_merge
// combines the two lanes into one stereo result and holds it in the output register
// ----------------------------------------------------------------------------
module hbds_merge (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 en,
	input  hbds_pkg::ctl_t                       ctl_s2,
	input  hbds_pkg::lane_out_t                  left_res,
	input  hbds_pkg::lane_out_t                  right_res,
	output logic                                 valid,
	output logic signed [hbds_pkg::SAMPLE_W-1:0] left_out,
	output logic signed [hbds_pkg::SAMPLE_W-1:0] right_out
);

	logic                                 valid_q;
	logic signed [hbds_pkg::SAMPLE_W-1:0] left_q;
	logic signed [hbds_pkg::SAMPLE_W-1:0] right_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			left_q  <= ctl_s2.pass ? left_res.wide  : left_res.filt;
			right_q <= ctl_s2.pass ? right_res.wide : right_res.filt;
		end
	end

	assign valid     = valid_q;
	assign left_out  = left_q;
	assign right_out = right_q;

endmodule

/* src/halfband_decimator_stereo_top.sv */
// ----------------------------------------------------------------------------
// halfband_decimator_stereo_top
// registers: a result passes the lane product and sum registers, then the merge output register
// throughput: one frame per cycle while not stalled; the lane pipeline stages advance together
// a stalled result holds the whole pipeline, so frame_stall follows result_stall while result_valid is high
// reset: delay lines cleared, phase even, decimation on, wide input; no clearing pass
// ----------------------------------------------------------------------------
module halfband_decimator_stereo_top #(
	parameter int TAP_COUNT = hbds_pkg::TAP_COUNT
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [hbds_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [hbds_pkg::CFG_DATA_W-1:0]         cfg_data,
	input  logic                                    frame_valid,
	output logic                                    frame_stall,
	input  logic signed [hbds_pkg::SAMPLE_W-1:0]    left_in,
	input  logic signed [hbds_pkg::SAMPLE_W-1:0]    right_in,
	output logic                                    result_valid,
	input  logic                                    result_stall,
	output logic signed [hbds_pkg::SAMPLE_W-1:0]    left_out,
	output logic signed [hbds_pkg::SAMPLE_W-1:0]    right_out
);

	logic                decimate_q;
	logic                narrow_q;
	logic                phase_q;
	logic                en;
	logic                accept;
	logic                emit;
	logic                shift_en;
	hbds_pkg::ctl_t      ctl_s1;
	hbds_pkg::ctl_t      ctl_s2;
	hbds_pkg::lane_out_t left_res;
	hbds_pkg::lane_out_t right_res;

	assign en          = !(result_valid && result_stall);
	assign frame_stall = !en;
	assign accept      = frame_valid && en;
	assign emit        = !decimate_q || !phase_q;
	assign shift_en    = accept && decimate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decimate_q <= 1'b1;
			narrow_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hbds_pkg::CFG_DECIMATE: decimate_q <= cfg_data[0];
				hbds_pkg::CFG_NARROW:   narrow_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
		end else if (shift_en) begin
			phase_q <= !phase_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1.valid <= accept && emit;
			ctl_s1.pass  <= !decimate_q;
			ctl_s2       <= ctl_s1;
		end
	end

	hbds_lane #(
		.TAP_COUNT(TAP_COUNT)
	) u_lane_left (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.shift_en(shift_en),
		.narrow  (narrow_q),
		.sample  (left_in),
		.res     (left_res)
	);

	hbds_lane #(
		.TAP_COUNT(TAP_COUNT)
	) u_lane_right (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.shift_en(shift_en),
		.narrow  (narrow_q),
		.sample  (right_in),
		.res     (right_res)
	);

	hbds_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.ctl_s2   (ctl_s2),
		.left_res (left_res),
		.right_res(right_res),
		.valid    (result_valid),
		.left_out (left_out),
		.right_out(right_out)
	);

`include "halfband_decimator_stereo_top_assert.svh"

	`HBDS_ASSERT_NOW(a_hold_back, result_valid && result_stall, frame_stall)
	`HBDS_ASSERT_NEXT(a_odd_silent, accept && decimate_q && phase_q, !ctl_s1.valid)
	`HBDS_ASSERT_NEXT(a_pass_every, accept && !decimate_q, ctl_s1.valid && ctl_s1.pass)
	`HBDS_ASSERT_NEXT(a_phase_flip, shift_en, phase_q != $past(phase_q))

endmodule
